// File: rtl/crp_pkg.sv
// Shared types and constants for the coordinate reply parser.
// Used by crp_scale and coordinate_reply_parser; depends on nothing else.
`default_nettype none

package crp_pkg;

  // Width of the seconds total
  localparam int unsigned AccW = 19;

  // Reply kinds
  localparam logic KindRa  = 1'b0;
  localparam logic KindDec = 1'b1;

  // Reply characters
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Parse positions; values above the last position of a kind act as idle
  localparam logic [3:0] PosIdle  = 4'd0;
  localparam logic [3:0] PosFirst = 4'd1;
  // Right ascension: HH:MM:SS# or HH:MM.T#
  localparam logic [3:0] RaHh0    = 4'd1;
  localparam logic [3:0] RaHh1    = 4'd2;
  localparam logic [3:0] RaSep1   = 4'd3;
  localparam logic [3:0] RaMm0    = 4'd4;
  localparam logic [3:0] RaMm1    = 4'd5;
  localparam logic [3:0] RaSep2   = 4'd6;
  localparam logic [3:0] RaSs0    = 4'd7;
  localparam logic [3:0] RaSs1    = 4'd8;
  localparam logic [3:0] RaEnd    = 4'd9;
  // Declination: sDD*MM# or sDD*MM:SS#
  localparam logic [3:0] DecSign  = 4'd1;
  localparam logic [3:0] DecDd0   = 4'd2;
  localparam logic [3:0] DecDd1   = 4'd3;
  localparam logic [3:0] DecDeg   = 4'd4;
  localparam logic [3:0] DecMm0   = 4'd5;
  localparam logic [3:0] DecMm1   = 4'd6;
  localparam logic [3:0] DecSep   = 4'd7;
  localparam logic [3:0] DecSs0   = 4'd8;
  localparam logic [3:0] DecSs1   = 4'd9;
  localparam logic [3:0] DecEnd   = 4'd10;

  // Scaling: v*2^32/86400 = v*2^25/675 and v*2^32/1296000 = v*2^25/10125.
  // 2^25 = 49710*675 + 182 = 3314*10125 + 182, so
  // q = v*whole + floor(v*182/div), the last term by reciprocal multiply.
  localparam logic [15:0] RaWhole   = 16'd49710;
  localparam logic [15:0] DecWhole  = 16'd3314;
  localparam logic [7:0]  FracPart  = 8'd182;
  localparam logic [13:0] RaDiv     = 14'd675;
  localparam logic [13:0] DecDiv    = 14'd10125;
  localparam int unsigned FracW     = 27;  // v*182 < 2^27
  localparam int unsigned RaShift   = 37;  // 27 + ceil(log2(675))
  localparam int unsigned DecShift  = 41;  // 27 + ceil(log2(10125))
  localparam longint unsigned RaRecipL  = ((64'd1 << RaShift) + 64'd674) / 64'd675;
  localparam longint unsigned DecRecipL = ((64'd1 << DecShift) + 64'd10124) / 64'd10125;
  localparam logic [27:0] RaRecip   = RaRecipL[27:0];
  localparam logic [27:0] DecRecip  = DecRecipL[27:0];
  localparam int unsigned ProdW     = 55;  // 27 x 28 bits
  localparam int unsigned QuoW      = 18;

  // Finished parse handed to the scaling pipeline
  typedef struct packed {
    logic            kind;
    logic            err;
    logic            long_fmt;
    logic            neg;
    logic [AccW-1:0] secs;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/coordinate_reply_parser.sv
// Top level of the coordinate reply parser: byte-wise reply parsing and the
// result stream. Depends on crp_pkg and crp_scale.
//
//  channel  | dir | tdata                 | tuser
//  s_axis   | in  | [7:0] data_byte       | [0] op
//  m_axis   | out | [31:0] angle          | [0] reply_kind [1] status [2] long_fmt
//
// One byte is accepted per cycle while s_axis_tready is high; the parse
// state updates in the same cycle. A reply's result reaches m_axis through
// the five registered stages of crp_scale; the first loads at the edge that
// accepts its closing byte. Reset (rst_ni low, asynchronous) returns the
// parser to idle and empties the pipeline. s_axis_tready drops only when
// all five stages hold results and m_axis_tready is low.
`default_nettype none

module coordinate_reply_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] angle
  output logic [2:0]       m_axis_tuser    // [0] reply_kind, [1] status, [2] long_fmt
);

  logic [3:0] pos_q, pos_d;
  logic kind_q, kind_d;
  logic neg_q, neg_d;
  logic lng_q, lng_d;
  logic [crp_pkg::AccW-1:0] acc_q, acc_d;

  logic [3:0] pos_c, pos_w;
  logic start;
  logic kind_c, neg_c, lng_c;
  logic [crp_pkg::AccW-1:0] acc_c;
  logic [7:0] b;
  logic [3:0] dig;
  logic is_dig;
  logic res_valid, res_err;
  logic s_fire;
  logic scale_ready;
  crp_pkg::item_t item;

  // Multiply-accumulate one digit, wrapped to the accumulator width
  function automatic logic [crp_pkg::AccW-1:0] acc_push(
    input logic [crp_pkg::AccW-1:0] a, input logic [5:0] m, input logic [3:0] d);
    logic [24:0] t;
    t = 25'(a) * 25'(m) + 25'(d);
    return t[crp_pkg::AccW-1:0];
  endfunction

  assign b      = s_axis_tdata;
  assign dig    = b[3:0];
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Parse one byte against the current position
  always_comb begin
    pos_c = pos_q;
    if (pos_q > crp_pkg::DecEnd ||
        (kind_q == crp_pkg::KindRa && pos_q > crp_pkg::RaEnd)) begin
      pos_c = crp_pkg::PosIdle;
    end
    start  = (pos_c == crp_pkg::PosIdle);
    kind_c = start ? s_axis_tuser[0] : kind_q;
    neg_c  = start ? 1'b0 : neg_q;
    acc_c  = start ? '0 : acc_q;
    lng_c  = start ? 1'b1 : lng_q;
    pos_w  = start ? crp_pkg::PosFirst : pos_c;
    is_dig = b inside {[crp_pkg::CharZero:crp_pkg::CharNine]};

    kind_d    = kind_c;
    neg_d     = neg_c;
    acc_d     = acc_c;
    lng_d     = lng_c;
    pos_d     = pos_w;
    res_valid = 1'b0;
    res_err   = 1'b0;

    if (start && b == crp_pkg::CharHash) begin
      // skip a single leading hash
    end else if (kind_c == crp_pkg::KindRa) begin
      case (pos_w)
        crp_pkg::RaHh0, crp_pkg::RaHh1, crp_pkg::RaMm0, crp_pkg::RaMm1,
        crp_pkg::RaSs0: begin
          if (!is_dig) begin
            res_valid = 1'b1;
            res_err   = 1'b1;
            pos_d     = crp_pkg::PosIdle;
          end else begin
            if (pos_w == crp_pkg::RaHh0) acc_d = crp_pkg::AccW'(dig);
            else if (pos_w == crp_pkg::RaMm0) acc_d = acc_push(acc_c, 6'd6, dig);
            else if (pos_w == crp_pkg::RaSs0)
              acc_d = acc_push(acc_c, lng_c ? 6'd6 : 6'd10, dig);
            else acc_d = acc_push(acc_c, 6'd10, dig);
            pos_d = pos_w + 4'd1;
          end
        end
        crp_pkg::RaSep1: begin
          if (b != crp_pkg::CharColon) begin
            res_valid = 1'b1;
            res_err   = 1'b1;
            pos_d     = crp_pkg::PosIdle;
          end else begin
            pos_d = crp_pkg::RaMm0;
          end
        end
        crp_pkg::RaSep2: begin
          if (b == crp_pkg::CharColon) begin
            lng_d = 1'b1;
            pos_d = crp_pkg::RaSs0;
          end else if (b == crp_pkg::CharDot) begin
            lng_d = 1'b0;
            pos_d = crp_pkg::RaSs0;
          end else begin
            res_valid = 1'b1;
            res_err   = 1'b1;
            pos_d     = crp_pkg::PosIdle;
          end
        end
        crp_pkg::RaSs1: begin
          if (lng_c) begin
            if (!is_dig) begin
              res_valid = 1'b1;
              res_err   = 1'b1;
              pos_d     = crp_pkg::PosIdle;
            end else begin
              acc_d = acc_push(acc_c, 6'd10, dig);
              pos_d = crp_pkg::RaEnd;
            end
          end else begin
            // short format closes here: tenths of a minute to seconds
            res_valid = 1'b1;
            res_err   = (b != crp_pkg::CharHash);
            pos_d     = crp_pkg::PosIdle;
            if (b == crp_pkg::CharHash) acc_d = acc_push(acc_c, 6'd6, 4'd0);
          end
        end
        default: begin
          res_valid = 1'b1;
          res_err   = (b != crp_pkg::CharHash);
          pos_d     = crp_pkg::PosIdle;
        end
      endcase
    end else begin
      case (pos_w)
        crp_pkg::DecSign: begin
          if (b == crp_pkg::CharPlus) begin
            neg_d = 1'b0;
            pos_d = crp_pkg::DecDd0;
          end else if (b == crp_pkg::CharMinus) begin
            neg_d = 1'b1;
            pos_d = crp_pkg::DecDd0;
          end else begin
            res_valid = 1'b1;
            res_err   = 1'b1;
            pos_d     = crp_pkg::PosIdle;
          end
        end
        crp_pkg::DecDd0, crp_pkg::DecDd1, crp_pkg::DecMm0, crp_pkg::DecMm1,
        crp_pkg::DecSs0, crp_pkg::DecSs1: begin
          if (!is_dig) begin
            res_valid = 1'b1;
            res_err   = 1'b1;
            pos_d     = crp_pkg::PosIdle;
          end else begin
            if (pos_w == crp_pkg::DecDd0) acc_d = crp_pkg::AccW'(dig);
            else if (pos_w == crp_pkg::DecMm0 || pos_w == crp_pkg::DecSs0)
              acc_d = acc_push(acc_c, 6'd6, dig);
            else acc_d = acc_push(acc_c, 6'd10, dig);
            pos_d = pos_w + 4'd1;
          end
        end
        crp_pkg::DecDeg: begin
          // degree mark: any byte
          pos_d = crp_pkg::DecMm0;
        end
        crp_pkg::DecSep: begin
          if (b == crp_pkg::CharHash) begin
            // short format: minutes to seconds
            lng_d     = 1'b0;
            acc_d     = acc_push(acc_c, 6'd60, 4'd0);
            res_valid = 1'b1;
            pos_d     = crp_pkg::PosIdle;
          end else if (b == crp_pkg::CharColon) begin
            lng_d = 1'b1;
            pos_d = crp_pkg::DecSs0;
          end else begin
            res_valid = 1'b1;
            res_err   = 1'b1;
            pos_d     = crp_pkg::PosIdle;
          end
        end
        default: begin
          res_valid = 1'b1;
          res_err   = (b != crp_pkg::CharHash);
          pos_d     = crp_pkg::PosIdle;
        end
      endcase
    end

    item = '{kind: kind_c, err: res_err, long_fmt: lng_d, neg: neg_d, secs: acc_d};
  end

  // Parse state advances on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= crp_pkg::PosIdle;
      kind_q <= crp_pkg::KindRa;
      neg_q  <= 1'b0;
      lng_q  <= 1'b1;
      acc_q  <= '0;
    end else if (s_fire) begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
      neg_q  <= neg_d;
      lng_q  <= lng_d;
      acc_q  <= acc_d;
    end
  end

  assign s_axis_tready = scale_ready;

  crp_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_fire && res_valid),
    .item_ready_o (scale_ready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_kind_o   (m_axis_tuser[0]),
    .res_status_o (m_axis_tuser[1]),
    .res_long_o   (m_axis_tuser[2]),
    .res_angle_o  (m_axis_tdata)
  );

  // Every result closes the reply
  a_result_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && res_valid) |=> (pos_q == crp_pkg::PosIdle))
    else $error("parser did not return to idle after a result");

  // Position never leaves the declination range
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= crp_pkg::DecEnd)
    else $error("parse position out of range");

  // A right-ascension reply never records a sign
  a_ra_no_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == crp_pkg::KindRa) |-> !neg_q)
    else $error("sign set during a right-ascension reply");

endmodule

`default_nettype wire

// File: rtl/crp_scale.sv
// Scaling pipeline: turns a seconds total into a 32-bit fraction of a turn
// and holds the result beat. Depends on crp_pkg.
`default_nettype none

module crp_scale (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  output logic               item_ready_o,
  input  wire crp_pkg::item_t item_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output logic               res_kind_o,
  output logic               res_status_o,
  output logic               res_long_o,
  output logic [31:0]        res_angle_o
);

  typedef struct packed {
    logic kind;
    logic err;
    logic long_fmt;
    logic neg;
  } meta_t;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  crp_pkg::item_t it1_q;
  meta_t m2_q, m3_q, m4_q;
  logic [crp_pkg::FracW-1:0] x2_q, x3_q, x4_q;
  logic [31:0] base2_q, base3_q, sum4_q;
  logic [crp_pkg::ProdW-1:0] p3_q;
  logic [crp_pkg::FracW-1:0] prod4_q;
  logic kind5_q, status5_q, long5_q;
  logic [31:0] angle5_q;

  logic [15:0] whole;
  logic [27:0] recip;
  logic [13:0] divisor;
  logic [34:0] base_full;
  logic [crp_pkg::FracW-1:0] x_d;
  logic [crp_pkg::ProdW-1:0] p_d;
  logic [crp_pkg::QuoW-1:0] quo;
  logic [31:0] prod_full;
  logic [31:0] ang_d;
  logic nz;

  // Each stage loads when empty or when the next one moves on
  assign rdy5 = !v5_q || res_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign item_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= item_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Stage 2: integer part of the scale and the fraction numerator
  always_comb begin
    whole     = (it1_q.kind == crp_pkg::KindDec) ? crp_pkg::DecWhole : crp_pkg::RaWhole;
    base_full = 35'(it1_q.secs) * 35'(whole);
    x_d       = crp_pkg::FracW'(it1_q.secs) * crp_pkg::FracW'(crp_pkg::FracPart);
  end

  // Stage 3: reciprocal multiply for the fraction quotient
  always_comb begin
    recip = (m2_q.kind == crp_pkg::KindDec) ? crp_pkg::DecRecip : crp_pkg::RaRecip;
    p_d   = crp_pkg::ProdW'(x2_q) * crp_pkg::ProdW'(recip);
  end

  // Stage 4: quotient, its back product for the remainder test, sum
  always_comb begin
    if (m3_q.kind == crp_pkg::KindDec) begin
      quo     = crp_pkg::QuoW'(p3_q >> crp_pkg::DecShift);
      divisor = crp_pkg::DecDiv;
    end else begin
      quo     = crp_pkg::QuoW'(p3_q >> crp_pkg::RaShift);
      divisor = crp_pkg::RaDiv;
    end
    prod_full = 32'(quo) * 32'(divisor);
  end

  // Stage 5: negate with ceiling for negative declination, zero on error
  always_comb begin
    nz = (x4_q != prod4_q);
    if (m4_q.err) begin
      ang_d = '0;
    end else if (m4_q.neg) begin
      // -(q + nz): ~q when a remainder exists, ~q + 1 otherwise
      ang_d = nz ? ~sum4_q : (~sum4_q + 32'd1);
    end else begin
      ang_d = sum4_q;
    end
  end

  // Payload registers advance with their stage
  always_ff @(posedge clk_i) begin
    if (rdy1) it1_q <= item_i;
    if (rdy2) begin
      m2_q    <= '{kind: it1_q.kind, err: it1_q.err, long_fmt: it1_q.long_fmt,
                   neg: it1_q.neg};
      x2_q    <= x_d;
      base2_q <= base_full[31:0];
    end
    if (rdy3) begin
      m3_q    <= m2_q;
      x3_q    <= x2_q;
      base3_q <= base2_q;
      p3_q    <= p_d;
    end
    if (rdy4) begin
      m4_q    <= m3_q;
      x4_q    <= x3_q;
      sum4_q  <= base3_q + 32'(quo);
      prod4_q <= prod_full[crp_pkg::FracW-1:0];
    end
    if (rdy5) begin
      kind5_q   <= m4_q.kind;
      status5_q <= m4_q.err;
      long5_q   <= m4_q.long_fmt && !m4_q.err;
      angle5_q  <= ang_d;
    end
  end

  assign res_valid_o  = v5_q;
  assign res_kind_o   = kind5_q;
  assign res_status_o = status5_q;
  assign res_long_o   = long5_q;
  assign res_angle_o  = angle5_q;

  // Back pressure only when every stage is full
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rdy1 |-> (v1_q && v2_q && v3_q && v4_q && v5_q))
    else $error("input blocked while the pipeline has a hole");

  // A stalled first stage keeps its item
  a_hold_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> (v1_q && $stable(it1_q)))
    else $error("first stage lost its item under stall");

  // Error results carry no angle and no format flag
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && status5_q) |-> (angle5_q == 32'd0 && !long5_q))
    else $error("error result with nonzero payload");

endmodule

`default_nettype wire

// File: bench/coordinate_reply_parser_tb.sv
// Testbench for coordinate_reply_parser: streams reply bytes in, predicts each
// parsed angle or error in a local parser model and checks every result beat.
// Depends on crp_pkg and the coordinate_reply_parser RTL.
`default_nettype none

module coordinate_reply_parser_tb;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;
  localparam logic FmtShort  = 1'b0;
  localparam logic FmtLong   = 1'b1;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned PhaseBytes = 200;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic        long_fmt;
    logic [31:0] angle;
  } coord_reply_t;

  typedef struct packed {
    logic         op;
    logic [7:0]   data;
    logic         typed;
    coord_reply_t want;
  } stim_row_t;

  localparam coord_reply_t NoReply = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic [0:0]  s_axis_tuser = 1'b0;    // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] angle
  logic [2:0]  m_axis_tuser;           // [0] reply_kind, [1] status, [2] long_fmt

  coord_reply_t pending_replies[$];
  stim_row_t    directed_rows[$];
  logic [7:0]   reply_bytes[$];
  logic         reply_op;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  fails = 0;
  int unsigned  idle_cycles = 0;
  bit           hold_request = 1'b0;
  bit           hold_served = 1'b0;

  // Parser state of the local model
  logic [3:0]               ps_pos = crp_pkg::PosIdle;
  logic                     ps_kind = crp_pkg::KindRa;
  logic                     ps_neg = 1'b0;
  logic [crp_pkg::AccW-1:0] ps_secs = '0;
  logic                     ps_long = 1'b1;

  coordinate_reply_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  function automatic coord_reply_t reply(input logic kind, input logic status,
                                         input logic long_fmt, input logic [31:0] angle);
    coord_reply_t r;
    r.kind = kind;
    r.status = status;
    r.long_fmt = long_fmt;
    r.angle = angle;
    return r;
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned n);
    return crp_pkg::CharZero + 8'(n);
  endfunction

  function automatic bit is_digit_char(input logic [7:0] b);
    return b >= crp_pkg::CharZero && b <= crp_pkg::CharNine;
  endfunction

  // Weight the running total and add one digit, truncated to the total's width
  function automatic logic [crp_pkg::AccW-1:0] shift_in(
    input logic [crp_pkg::AccW-1:0] acc, input int unsigned mul, input logic [7:0] b);
    logic [31:0] t;
    t = acc * mul + (b - crp_pkg::CharZero);
    return t[crp_pkg::AccW-1:0];
  endfunction

  function automatic bit reject_reply(output coord_reply_t r);
    r = reply(ps_kind, StatusErr, FmtShort, 32'h0);
    ps_pos = crp_pkg::PosIdle;
    return 1'b1;
  endfunction

  // Scale the seconds total to a fraction of a turn: floor for RA and +Dec,
  // ceiling then negate for -Dec, which is floor of the negative value
  function automatic bit finish_angle(output coord_reply_t r);
    logic [63:0] num;
    logic [63:0] q;
    num = {13'd0, ps_secs, 32'd0};
    if (ps_kind == crp_pkg::KindRa) begin
      q = num / 64'd86400;
    end else begin
      q = num / 64'd1296000;
      if (ps_neg) begin
        if (num % 64'd1296000 != 64'd0) q = q + 64'd1;
        q = -q;
      end
    end
    r = reply(ps_kind, StatusOk, ps_long, q[31:0]);
    ps_pos = crp_pkg::PosIdle;
    return 1'b1;
  endfunction

  function automatic bit ra_reply_byte(input logic [7:0] b, output coord_reply_t r);
    r = NoReply;
    case (ps_pos)
      crp_pkg::RaHh0, crp_pkg::RaHh1, crp_pkg::RaMm0, crp_pkg::RaMm1,
      crp_pkg::RaSs0: begin
        if (!is_digit_char(b)) return reject_reply(r);
        if (ps_pos == crp_pkg::RaHh0) ps_secs = crp_pkg::AccW'(b - crp_pkg::CharZero);
        else if (ps_pos == crp_pkg::RaMm0) ps_secs = shift_in(ps_secs, 6, b);
        else if (ps_pos == crp_pkg::RaSs0) ps_secs = shift_in(ps_secs, ps_long ? 6 : 10, b);
        else ps_secs = shift_in(ps_secs, 10, b);
        ps_pos = ps_pos + 4'd1;
        return 1'b0;
      end
      crp_pkg::RaSep1: begin
        if (b != crp_pkg::CharColon) return reject_reply(r);
        ps_pos = crp_pkg::RaMm0;
        return 1'b0;
      end
      crp_pkg::RaSep2: begin
        if (b == crp_pkg::CharColon) ps_long = FmtLong;
        else if (b == crp_pkg::CharDot) ps_long = FmtShort;
        else return reject_reply(r);
        ps_pos = crp_pkg::RaSs0;
        return 1'b0;
      end
      crp_pkg::RaSs1: begin
        if (ps_long) begin
          if (!is_digit_char(b)) return reject_reply(r);
          ps_secs = shift_in(ps_secs, 10, b);
          ps_pos = crp_pkg::RaEnd;
          return 1'b0;
        end
        // tenths of a minute: six seconds each
        if (b != crp_pkg::CharHash) return reject_reply(r);
        ps_secs = shift_in(ps_secs, 6, crp_pkg::CharZero);
        return finish_angle(r);
      end
      default: begin
        if (b != crp_pkg::CharHash) return reject_reply(r);
        return finish_angle(r);
      end
    endcase
  endfunction

  function automatic bit dec_reply_byte(input logic [7:0] b, output coord_reply_t r);
    r = NoReply;
    case (ps_pos)
      crp_pkg::DecSign: begin
        if (b == crp_pkg::CharPlus) ps_neg = 1'b0;
        else if (b == crp_pkg::CharMinus) ps_neg = 1'b1;
        else return reject_reply(r);
        ps_pos = crp_pkg::DecDd0;
        return 1'b0;
      end
      crp_pkg::DecDd0, crp_pkg::DecDd1, crp_pkg::DecMm0, crp_pkg::DecMm1,
      crp_pkg::DecSs0, crp_pkg::DecSs1: begin
        if (!is_digit_char(b)) return reject_reply(r);
        if (ps_pos == crp_pkg::DecDd0) ps_secs = crp_pkg::AccW'(b - crp_pkg::CharZero);
        else if (ps_pos == crp_pkg::DecMm0 || ps_pos == crp_pkg::DecSs0)
          ps_secs = shift_in(ps_secs, 6, b);
        else ps_secs = shift_in(ps_secs, 10, b);
        ps_pos = ps_pos + 4'd1;
        return 1'b0;
      end
      // degree mark: any byte passes
      crp_pkg::DecDeg: begin
        ps_pos = crp_pkg::DecMm0;
        return 1'b0;
      end
      crp_pkg::DecSep: begin
        if (b == crp_pkg::CharHash) begin
          ps_long = FmtShort;
          ps_secs = shift_in(ps_secs, 60, crp_pkg::CharZero);
          return finish_angle(r);
        end
        if (b != crp_pkg::CharColon) return reject_reply(r);
        ps_long = FmtLong;
        ps_pos = crp_pkg::DecSs0;
        return 1'b0;
      end
      default: begin
        if (b != crp_pkg::CharHash) return reject_reply(r);
        return finish_angle(r);
      end
    endcase
  endfunction

  // Advance the model by one byte; returns 1 when the byte closes a reply
  function automatic bit parse_reply_byte(input logic op, input logic [7:0] b,
                                          output coord_reply_t r);
    r = NoReply;
    if (ps_pos > crp_pkg::DecEnd || (ps_kind == crp_pkg::KindRa && ps_pos > crp_pkg::RaEnd))
      ps_pos = crp_pkg::PosIdle;
    if (ps_pos == crp_pkg::PosIdle) begin
      ps_kind = op;
      ps_neg = 1'b0;
      ps_secs = '0;
      ps_long = FmtLong;
      ps_pos = crp_pkg::PosFirst;
      if (b == crp_pkg::CharHash) return 1'b0;
    end
    if (ps_kind == crp_pkg::KindRa) return ra_reply_byte(b, r);
    return dec_reply_byte(b, r);
  endfunction

  task automatic add_row(input logic op, input logic [7:0] b, input logic typed,
                         input coord_reply_t want);
    stim_row_t row;
    row.op = op;
    row.data = b;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Offer one beat, wait for acceptance, then queue what it should produce
  task automatic send_beat(input logic op, input logic [7:0] b, input logic typed,
                           input coord_reply_t want);
    coord_reply_t r;
    bit           closes;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    closes = parse_reply_byte(op, b, r);
    if (typed) pending_replies.push_back(want);
    else if (closes) pending_replies.push_back(r);
  endtask

  // Mostly in range, now and then any two digits
  function automatic int unsigned pick_value(input int unsigned max);
    return ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(max);
  endfunction

  task automatic push_pair(input int unsigned v);
    reply_bytes.push_back(digit_char(v / 10));
    reply_bytes.push_back(digit_char(v % 10));
  endtask

  // Build one reply: mostly well formed, some damaged or cut short, some noise
  task automatic gen_reply();
    int unsigned cut;
    reply_bytes.delete();
    reply_op = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(4, 1)) reply_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(3) == 0) reply_bytes.push_back(crp_pkg::CharHash);
    if (reply_op == crp_pkg::KindRa) begin
      push_pair(pick_value(23));
      reply_bytes.push_back(crp_pkg::CharColon);
      push_pair(pick_value(59));
      if ($urandom_range(1)) begin
        reply_bytes.push_back(crp_pkg::CharColon);
        push_pair(pick_value(59));
      end else begin
        reply_bytes.push_back(crp_pkg::CharDot);
        reply_bytes.push_back(digit_char($urandom_range(9)));
      end
    end else begin
      if ($urandom_range(7) == 0) reply_bytes.push_back(8'($urandom_range(255)));
      else reply_bytes.push_back($urandom_range(1) ? crp_pkg::CharMinus : crp_pkg::CharPlus);
      push_pair(pick_value(90));
      reply_bytes.push_back(8'($urandom_range(255)));
      push_pair(pick_value(59));
      if ($urandom_range(1)) begin
        reply_bytes.push_back(crp_pkg::CharColon);
        push_pair(pick_value(59));
      end
    end
    reply_bytes.push_back(crp_pkg::CharHash);
    if ($urandom_range(7) == 0) begin
      reply_bytes[$urandom_range(reply_bytes.size() - 1)] = 8'($urandom_range(255));
    end else if ($urandom_range(15) == 0) begin
      cut = $urandom_range(reply_bytes.size() - 1, 1);
      repeat (cut) reply_bytes.delete(reply_bytes.size() - 1);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off to back up the pipeline
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    coord_reply_t got;
    coord_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = reply(m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2], m_axis_tdata);
      if (pending_replies.size() == 0) begin
        fails++;
        $display("%0t: expected no beat, got kind %0d status %0d long %0d angle %h",
                 $time, got.kind, got.status, got.long_fmt, got.angle);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          fails++;
          $display("%0t: expected %0d/%0d/%0d/%h, got %0d/%0d/%0d/%h (kind/status/long/angle)",
                   $time, want.kind, want.status, want.long_fmt, want.angle,
                   got.kind, got.status, got.long_fmt, got.angle);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("coordinate_reply_parser: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    int unsigned sent;
    idle_by_phase = '{0, 67, 0, 15};
    stall_by_phase = '{0, 0, 67, 15};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad first bytes of both kinds, a doubled leading hash,
    // an out-of-range short RA, a short -90 Dec with a junk degree mark,
    // and a wrong separator
    add_row(crp_pkg::KindRa,  8'hFF, 1'b1,
            reply(crp_pkg::KindRa, StatusErr, FmtShort, 32'h0));
    add_row(crp_pkg::KindDec, 8'h00, 1'b1,
            reply(crp_pkg::KindDec, StatusErr, FmtShort, 32'h0));
    add_row(crp_pkg::KindDec, crp_pkg::CharHash, 1'b0, NoReply);
    add_row(crp_pkg::KindDec, crp_pkg::CharHash, 1'b1,
            reply(crp_pkg::KindDec, StatusErr, FmtShort, 32'h0));
    add_row(crp_pkg::KindRa,  crp_pkg::CharHash, 1'b0, NoReply);
    add_row(crp_pkg::KindRa,  digit_char(9), 1'b0, NoReply);
    add_row(crp_pkg::KindRa,  digit_char(9), 1'b0, NoReply);
    add_row(crp_pkg::KindRa,  crp_pkg::CharColon, 1'b0, NoReply);
    add_row(crp_pkg::KindRa,  digit_char(9), 1'b0, NoReply);
    add_row(crp_pkg::KindRa,  digit_char(9), 1'b0, NoReply);
    add_row(crp_pkg::KindRa,  crp_pkg::CharDot, 1'b0, NoReply);
    add_row(crp_pkg::KindRa,  digit_char(9), 1'b0, NoReply);
    add_row(crp_pkg::KindRa,  crp_pkg::CharHash, 1'b0, NoReply);
    add_row(crp_pkg::KindDec, crp_pkg::CharMinus, 1'b0, NoReply);
    add_row(crp_pkg::KindDec, digit_char(9), 1'b0, NoReply);
    add_row(crp_pkg::KindDec, digit_char(0), 1'b0, NoReply);
    add_row(crp_pkg::KindDec, 8'hFF, 1'b0, NoReply);
    add_row(crp_pkg::KindDec, digit_char(0), 1'b0, NoReply);
    add_row(crp_pkg::KindDec, digit_char(0), 1'b0, NoReply);
    add_row(crp_pkg::KindDec, crp_pkg::CharHash, 1'b1,
            reply(crp_pkg::KindDec, StatusOk, FmtShort, 32'hC000_0000));
    add_row(crp_pkg::KindRa,  digit_char(1), 1'b0, NoReply);
    add_row(crp_pkg::KindRa,  digit_char(2), 1'b0, NoReply);
    add_row(crp_pkg::KindRa,  crp_pkg::CharDot, 1'b1,
            reply(crp_pkg::KindRa, StatusErr, FmtShort, 32'h0));
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                directed_rows[i].want);
    end

    // Random replies over the idle/stall phases; the first one also holds
    // the receiver off long enough to fill the pipeline
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      if (p == 0) hold_request = 1'b1;
      sent = 0;
      while (sent < PhaseBytes) begin
        gen_reply();
        foreach (reply_bytes[i]) begin
          send_beat((i == 0) ? reply_op : logic'($urandom_range(1)), reply_bytes[i],
                    1'b0, NoReply);
        end
        sent += reply_bytes.size();
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain: results trail their closing byte by the scaling pipeline
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0) begin
      $display("coordinate_reply_parser: match");
    end else begin
      $display("coordinate_reply_parser: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
